FILE: design/tcw_pkg.sv
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS = 25;
  localparam int DEF_QUEUE_DEPTH = 2;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;
  localparam int ADDR_W = 11;
  localparam int POS_W = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CODE_NUL = 8'd0;

  localparam logic [3:0] FG_WHITE = 4'd15;
  localparam logic [3:0] BG_BLACK = 4'd0;
  localparam logic [ATTR_W-1:0] RESET_ATTR = {BG_BLACK, FG_WHITE};
  localparam logic [CELL_W-1:0] CELL_RESET = {RESET_ATTR, CODE_SPACE};

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_TAB,
    OP_BACKSPACE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_data;
    logic [POS_W-1:0]     cursor_position;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_column;
  } res_t;

endpackage

FILE: design/text_console_writer.sv
// Text console writer: an SCREEN_ROWS x SCREEN_COLUMNS screen of 16-bit cells (character in
// the low byte, attribute in the high byte) and a cursor. Items are pushed into a small
// command queue and carried out one at a time; each gives one result with the cursor after
// the item, and the cell for a read. Newline, tab and a backspace at column 0 go from idle
// straight to the reply state; a put or any other backspace passes through a write state; a
// read through divide, remainder, look and read-wait states (no read wait when its row has
// not been written since reset or since it was scrolled out, and a reply straight from
// divide past the end of the screen; the row index comes from a reciprocal multiplication).
// Scrolling rotates a row base register and marks the old top line as blank; a row is filled
// with its blank value (space in white on black after reset, zero after a scroll) by a fill
// state on its first write. No clearing pass is needed after reset. The user must write the
// text_colour register through cfg_we/cfg_data only while the block is idle (not enforced).
module text_console_writer import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_COLUMNS,
  parameter int SCREEN_ROWS = DEF_ROWS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_kind,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [ADDR_W-1:0]    in_cell_address,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [CELL_W-1:0]    out_cell_data,
  output logic [POS_W-1:0]     out_cursor_position,
  output logic [ROW_OUT_W-1:0] out_cursor_row,
  output logic [COL_OUT_W-1:0] out_cursor_column,
  input  logic                 cfg_we,
  input  logic [ATTR_W-1:0]    cfg_data
);

  logic [ATTR_W-1:0]       colour_r;
  cmd_t                    cmd;
  logic                    cmd_empty;
  logic                    cmd_pop;
  res_t                    res;
  logic                    res_push;
  logic                    res_full;
  logic [$bits(res_t)-1:0] res_bits;
  res_t                    res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r <= RESET_ATTR;
    end else if (cfg_we) begin
      colour_r <= cfg_data;
    end
  end

  tcw_front #(
    .QDEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_kind        (in_kind),
    .in_char_code   (in_char_code),
    .in_cell_address(in_cell_address),
    .in_full        (in_full),
    .cmd            (cmd),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop)
  );

  tcw_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .text_colour(colour_r),
    .res        (res),
    .res_push   (res_push),
    .res_full   (res_full)
  );

  tcw_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(res),
    .full   (res_full),
    .pop    (out_pop),
    .rd_data(res_bits),
    .empty  (out_empty)
  );

  assign res_out = res_t'(res_bits);
  assign out_cell_data = res_out.cell_data;
  assign out_cursor_position = res_out.cursor_position;
  assign out_cursor_row = res_out.cursor_row;
  assign out_cursor_column = res_out.cursor_column;

endmodule

FILE: design/tcw_fifo.sv
module tcw_fifo import tcw_pkg::*; #(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [AW-1:0]    wp_r;
  logic [AW-1:0]    rp_r;
  logic [CNTW-1:0]  count_r;
  logic             do_push;
  logic             do_pop;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    logic [AW-1:0] n;
    if (p == AW'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  assign full = (count_r == CNTW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_data = store_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= ptr_next(wp_r);
      end
      if (do_pop) begin
        rp_r <= ptr_next(rp_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/tcw_front.sv
module tcw_front import tcw_pkg::*; #(
  parameter int QDEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_kind,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ADDR_W-1:0] in_cell_address,
  output logic              in_full,
  output cmd_t              cmd,
  output logic              cmd_empty,
  input  logic              cmd_pop
);

  cmd_t                 cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  always_comb begin
    cmd_in.char_code = in_char_code;
    cmd_in.cell_address = in_cell_address;
    if (in_kind) begin
      cmd_in.op = OP_READ;
    end else begin
      case (in_char_code)
        CODE_NEWLINE:   cmd_in.op = OP_NEWLINE;
        CODE_TAB:       cmd_in.op = OP_TAB;
        CODE_BACKSPACE: cmd_in.op = OP_BACKSPACE;
        default:        cmd_in.op = OP_PUT;
      endcase
    end
  end

  tcw_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QDEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .wr_data(cmd_in),
    .full   (in_full),
    .pop    (cmd_pop),
    .rd_data(cmd_bits),
    .empty  (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_bits);

endmodule

FILE: design/tcw_back.sv
module tcw_back import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_COLUMNS,
  parameter int SCREEN_ROWS = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic [ATTR_W-1:0] text_colour,
  output res_t              res,
  output logic              res_push,
  input  logic              res_full
);

  localparam int CW = $clog2(SCREEN_COLUMNS);
  localparam int RW = $clog2(SCREEN_ROWS);
  localparam int MW = RW + CW;
  localparam int MEM_DEPTH = SCREEN_ROWS * (2 ** CW);
  localparam int PW = $clog2(SCREEN_ROWS * SCREEN_COLUMNS) + POS_W;
  localparam int XR = RW + ROW_OUT_W;
  localparam int XC = CW + COL_OUT_W;
  // row = (address * RECIP) >> DSH, exact for every ADDR_W-bit address
  localparam int DSH = ADDR_W + CW;
  localparam int RECIP = (2 ** DSH + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS;
  localparam int PRW = 2 * ADDR_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_LOOK,
    ST_RDWAIT,
    ST_FILL,
    ST_WRITE,
    ST_REPLY
  } state_t;

  state_t                 state_r;
  logic [RW-1:0]          row_r;
  logic [CW-1:0]          col_r;
  logic [RW-1:0]          base_r;
  logic [SCREEN_ROWS-1:0] row_valid_r;
  logic [SCREEN_ROWS-1:0] row_blank_r;
  logic [ADDR_W-1:0]      a_r;
  logic [RW-1:0]          r_r;
  logic [RW-1:0]          wr_row_r;
  logic [CW-1:0]          wr_col_r;
  logic [CELL_W-1:0]      wr_data_r;
  logic [CW-1:0]          fill_cnt_r;
  logic [CELL_W-1:0]      fill_val_r;
  logic [CELL_W-1:0]      data_r;
  logic [CELL_W-1:0]      rd_data_r;
  logic [CELL_W-1:0]      screen_r [MEM_DEPTH];

  logic [RW-1:0]     p_cur;
  logic [RW-1:0]     p_rd;
  logic [RW-1:0]     look_row;
  logic              look_valid;
  logic [CELL_W-1:0] look_fill;
  logic [CW:0]       col_inc;
  logic [CW:0]       tab_col;
  logic              at_bottom;
  logic [RW-1:0]     row_wrap;
  logic [RW-1:0]     base_next;
  logic [PRW-1:0]    quo_prod;
  logic [ADDR_W-1:0] quo;
  logic [ADDR_W-1:0] row_start;
  logic              mem_we;
  logic [MW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [MW-1:0]     mem_raddr;
  logic [PW-1:0]     pos_w;
  logic [XR-1:0]     row_w;
  logic [XC-1:0]     col_w;

  // logical row to physical row through the rotating base
  function automatic logic [RW-1:0] phys(input logic [RW-1:0] r, input logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (s >= (RW + 1)'(SCREEN_ROWS)) begin
      s = s - (RW + 1)'(SCREEN_ROWS);
    end
    return s[RW-1:0];
  endfunction

  assign p_cur = phys(row_r, base_r);
  assign p_rd = phys(r_r, base_r);
  assign look_row = (state_r == ST_LOOK) ? p_rd : p_cur;
  assign look_valid = row_valid_r[look_row];
  assign look_fill = row_blank_r[look_row] ? CELL_RESET : '0;

  assign col_inc = {1'b0, col_r} + 1'b1;
  assign tab_col = {1'b0, col_r[CW-1:2], 2'b00} + (CW + 1)'(4);
  assign at_bottom = (row_r == RW'(SCREEN_ROWS - 1));
  assign row_wrap = at_bottom ? '0 : row_r + 1'b1;
  assign base_next = (base_r == RW'(SCREEN_ROWS - 1)) ? '0 : base_r + 1'b1;

  assign quo_prod = PRW'(a_r) * PRW'(RECIP);
  assign quo = ADDR_W'(quo_prod >> DSH);
  assign row_start = ADDR_W'(r_r) * ADDR_W'(SCREEN_COLUMNS);

  assign cmd_pop = (state_r == ST_IDLE) && !cmd_empty;

  assign mem_we = (state_r == ST_FILL) || (state_r == ST_WRITE);
  assign mem_waddr = {wr_row_r, (state_r == ST_FILL) ? fill_cnt_r : wr_col_r};
  assign mem_wdata = (state_r == ST_FILL) ? fill_val_r : wr_data_r;
  assign mem_raddr = {p_rd, a_r[CW-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= screen_r[mem_raddr];
  end

  assign pos_w = PW'(row_r) * PW'(SCREEN_COLUMNS) + PW'(col_r);
  assign row_w = XR'(row_r);
  assign col_w = XC'(col_r);

  assign res.cell_data = data_r;
  assign res.cursor_position = pos_w[POS_W-1:0];
  assign res.cursor_row = row_w[ROW_OUT_W-1:0];
  assign res.cursor_column = col_w[COL_OUT_W-1:0];
  assign res_push = (state_r == ST_REPLY) && !res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r <= '0;
      col_r <= '0;
      base_r <= '0;
      row_valid_r <= '0;
      row_blank_r <= '1;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!cmd_empty) begin
            data_r <= '0;
            fill_cnt_r <= '0;
            fill_val_r <= look_fill;
            wr_row_r <= p_cur;
            case (cmd.op)
              OP_READ: begin
                a_r <= cmd.cell_address;
                state_r <= ST_DIV;
              end
              OP_NEWLINE: begin
                col_r <= '0;
                if (at_bottom) begin
                  // scroll: oldest line becomes the new, zeroed bottom line
                  base_r <= base_next;
                  row_valid_r[base_r] <= 1'b0;
                  row_blank_r[base_r] <= 1'b0;
                end else begin
                  row_r <= row_r + 1'b1;
                end
                state_r <= ST_REPLY;
              end
              OP_TAB: begin
                if (tab_col >= (CW + 1)'(SCREEN_COLUMNS)) begin
                  col_r <= '0;
                  row_r <= row_wrap;
                end else begin
                  col_r <= tab_col[CW-1:0];
                end
                state_r <= ST_REPLY;
              end
              OP_BACKSPACE: begin
                if (col_r != '0) begin
                  col_r <= col_r - 1'b1;
                  wr_col_r <= col_r - 1'b1;
                  wr_data_r <= {text_colour, CODE_NUL};
                  state_r <= look_valid ? ST_WRITE : ST_FILL;
                end else begin
                  state_r <= ST_REPLY;
                end
              end
              OP_PUT: begin
                wr_col_r <= col_r;
                wr_data_r <= {text_colour, cmd.char_code};
                if (col_inc >= (CW + 1)'(SCREEN_COLUMNS)) begin
                  col_r <= '0;
                  row_r <= row_wrap;
                end else begin
                  col_r <= col_inc[CW-1:0];
                end
                state_r <= look_valid ? ST_WRITE : ST_FILL;
              end
              default: begin
                state_r <= ST_REPLY;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (quo >= ADDR_W'(SCREEN_ROWS)) begin
            data_r <= '0;
            state_r <= ST_REPLY;
          end else begin
            r_r <= quo[RW-1:0];
            state_r <= ST_REM;
          end
        end
        ST_REM: begin
          a_r <= a_r - row_start;
          state_r <= ST_LOOK;
        end
        ST_LOOK: begin
          if (look_valid) begin
            state_r <= ST_RDWAIT;
          end else begin
            data_r <= look_fill;
            state_r <= ST_REPLY;
          end
        end
        ST_RDWAIT: begin
          data_r <= rd_data_r;
          state_r <= ST_REPLY;
        end
        ST_FILL: begin
          fill_cnt_r <= fill_cnt_r + 1'b1;
          if (fill_cnt_r == CW'(SCREEN_COLUMNS - 1)) begin
            row_valid_r[wr_row_r] <= 1'b1;
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state_r <= ST_REPLY;
        end
        ST_REPLY: begin
          if (!res_full) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/text_console_writer_tb.sv
module text_console_writer_tb;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = DEF_COLUMNS;
  localparam int ROWS = DEF_ROWS;
  localparam int CELLS = COLS * ROWS;
  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 120;
  localparam int PLAN_LEN = 23;

  typedef struct {
    logic              kind;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    res_t              want;
  } step_t;

  localparam res_t HOME_BLANK = '{CELL_RESET, '0, '0, '0};
  localparam res_t HOME_ZERO = '0;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic                 in_kind = 1'b0;
  logic [CHAR_W-1:0]    in_char_code = '0;
  logic [ADDR_W-1:0]    in_cell_address = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [CELL_W-1:0]    out_cell_data;
  logic [POS_W-1:0]     out_cursor_position;
  logic [ROW_OUT_W-1:0] out_cursor_row;
  logic [COL_OUT_W-1:0] out_cursor_column;
  logic                 cfg_we = 1'b0;
  logic [ATTR_W-1:0]    cfg_data = '0;

  text_console_writer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_kind             (in_kind),
    .in_char_code        (in_char_code),
    .in_cell_address     (in_cell_address),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_cell_data       (out_cell_data),
    .out_cursor_position (out_cursor_position),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_column   (out_cursor_column),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // console model
  logic [CELL_W-1:0] screen_model [CELLS];
  int                row_cur;
  int                col_cur;
  logic [ATTR_W-1:0] colour_now;
  int                scroll_cnt = 0;
  int                bottom_wrap_cnt = 0;

  res_t cursor_reports [$];
  int   err_cnt = 0;
  int   checked_cnt = 0;
  int   sent_cnt = 0;
  int   snd_idle = 14;
  int   rcv_idle = 61;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  step_t plan [PLAN_LEN] = '{
    '{KIND_READ, 8'h00, 11'd0,    1'b1, HOME_BLANK},
    '{KIND_READ, 8'h00, 11'd1999, 1'b1, HOME_BLANK},
    '{KIND_READ, 8'h00, 11'd2000, 1'b1, HOME_ZERO},
    '{KIND_READ, 8'hFF, 11'd2047, 1'b1, HOME_ZERO},
    '{KIND_PUT,  CODE_BACKSPACE, 11'd0, 1'b1, HOME_ZERO},
    '{KIND_PUT,  8'h41, 11'd0,    1'b0, HOME_ZERO},
    '{KIND_PUT,  8'hFF, 11'd2047, 1'b0, HOME_ZERO},
    '{KIND_PUT,  CODE_NUL, 11'd0, 1'b0, HOME_ZERO},
    '{KIND_PUT,  CODE_SPACE, 11'd0, 1'b0, HOME_ZERO},
    '{KIND_PUT,  CODE_TAB, 11'd0, 1'b0, HOME_ZERO},
    '{KIND_PUT,  CODE_TAB, 11'd0, 1'b0, HOME_ZERO},
    '{KIND_READ, 8'h00, 11'd1,    1'b0, HOME_ZERO},
    '{KIND_PUT,  CODE_BACKSPACE, 11'd0, 1'b0, HOME_ZERO},
    '{KIND_READ, 8'h00, 11'd11,   1'b0, HOME_ZERO},
    '{KIND_PUT,  CODE_NEWLINE, 11'd0, 1'b0, HOME_ZERO},
    '{KIND_READ, 8'h00, 11'h400,  1'b0, HOME_ZERO},
    '{KIND_PUT,  8'h7F, 11'd0,    1'b0, HOME_ZERO},
    '{KIND_PUT,  8'h80, 11'd0,    1'b0, HOME_ZERO},
    '{KIND_READ, 8'h00, 11'd80,   1'b0, HOME_ZERO},
    '{KIND_PUT,  CODE_TAB, 11'd0, 1'b0, HOME_ZERO},
    '{KIND_PUT,  CODE_NEWLINE, 11'd0, 1'b0, HOME_ZERO},
    '{KIND_READ, 8'h00, 11'd3,    1'b0, HOME_ZERO},
    '{KIND_READ, 8'h00, 11'h3FF,  1'b0, HOME_ZERO}
  };

  function automatic void next_line();
    col_cur = 0;
    row_cur++;
    if (row_cur >= ROWS) begin
      row_cur = 0;
      bottom_wrap_cnt++;
    end
  endfunction

  function automatic res_t console_apply(logic kind, logic [CHAR_W-1:0] ch,
                                         logic [ADDR_W-1:0] addr);
    res_t r;
    r = '0;
    if (kind == KIND_PUT) begin
      case (ch)
        CODE_NEWLINE: begin
          col_cur = 0;
          if (row_cur >= ROWS - 1) begin
            for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = '0;
            scroll_cnt++;
          end else begin
            row_cur++;
          end
        end
        CODE_TAB: begin
          col_cur += 4 - (col_cur % 4);
          if (col_cur >= COLS) next_line();
        end
        CODE_BACKSPACE: begin
          if (col_cur > 0) begin
            col_cur--;
            screen_model[row_cur * COLS + col_cur] = {colour_now, CODE_NUL};
          end
        end
        default: begin
          screen_model[row_cur * COLS + col_cur] = {colour_now, ch};
          col_cur++;
          if (col_cur >= COLS) next_line();
        end
      endcase
    end else if (addr < CELLS) begin
      r.cell_data = screen_model[addr];
    end
    r.cursor_position = POS_W'(row_cur * COLS + col_cur);
    r.cursor_row = ROW_OUT_W'(row_cur);
    r.cursor_column = COL_OUT_W'(col_cur);
    return r;
  endfunction

  task automatic send_item(logic kind, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr,
                           bit typed, res_t want);
    res_t predicted;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_kind <= kind;
    in_char_code <= ch;
    in_cell_address <= addr;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predicted = console_apply(kind, ch, addr);
    cursor_reports.push_back(typed ? want : predicted);
    sent_cnt++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (cursor_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_colour(logic [ATTR_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    colour_now = value;
  endtask

  // bursts of well-formed console traffic with some noise mixed in
  task automatic run_random(int n);
    int done;
    int pick;
    int len;
    int a;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) len = $urandom_range(1, 90);
      else if (pick < 50) len = $urandom_range(1, 30);
      else if (pick < 62) len = $urandom_range(1, 24);
      else if (pick < 72) len = $urandom_range(1, 8);
      else if (pick < 92) len = $urandom_range(1, 6);
      else len = 1;
      for (int k = 0; k < len; k++) begin
        if (pick < 35) begin
          send_item(KIND_PUT, CHAR_W'($urandom_range(0, 255)), ADDR_W'($urandom), 1'b0,
                    HOME_ZERO);
        end else if (pick < 50) begin
          send_item(KIND_PUT, CODE_NEWLINE, '0, 1'b0, HOME_ZERO);
        end else if (pick < 62) begin
          send_item(KIND_PUT, CODE_TAB, '0, 1'b0, HOME_ZERO);
        end else if (pick < 72) begin
          send_item(KIND_PUT, CODE_BACKSPACE, '0, 1'b0, HOME_ZERO);
        end else if (pick < 92) begin
          case ($urandom_range(0, 3))
            0: begin
              a = row_cur * COLS + col_cur - int'($urandom_range(0, 4));
              if (a < 0) a = 0;
            end
            1: a = $urandom_range(0, CELLS - 1);
            2: a = $urandom_range(0, 2047);
            default: a = $urandom_range(CELLS - COLS, CELLS - 1);
          endcase
          send_item(KIND_READ, CHAR_W'($urandom), ADDR_W'(a), 1'b0, HOME_ZERO);
        end else begin
          send_item(logic'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                    ADDR_W'($urandom_range(0, 2047)), 1'b0, HOME_ZERO);
        end
        done++;
      end
    end
  endtask

  // receiver: random pops, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_tog;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (cursor_reports.size() == 0) begin
        $error("unexpected result transfer: cell_data %h cursor_position %0d",
               out_cell_data, out_cursor_position);
        err_cnt++;
      end else begin
        want = cursor_reports.pop_front();
        checked_cnt++;
        if (out_cell_data !== want.cell_data) begin
          $error("cell_data: expected %h, actual %h", want.cell_data, out_cell_data);
          err_cnt++;
        end
        if (out_cursor_position !== want.cursor_position) begin
          $error("cursor_position: expected %0d, actual %0d", want.cursor_position,
                 out_cursor_position);
          err_cnt++;
        end
        if (out_cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, actual %0d", want.cursor_row, out_cursor_row);
          err_cnt++;
        end
        if (out_cursor_column !== want.cursor_column) begin
          $error("cursor_column: expected %0d, actual %0d", want.cursor_column,
                 out_cursor_column);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_model[i] = CELL_RESET;
    row_cur = 0;
    col_cur = 0;
    colour_now = RESET_ATTR;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_item(plan[i].kind, plan[i].ch, plan[i].addr, plan[i].typed,
                                plan[i].want);

    set_colour(8'h00);
    run_random(400);

    snd_idle = 61;
    rcv_idle = 14;
    set_colour(8'hFF);
    run_random(400);

    snd_idle = 0;
    rcv_idle = 0;
    set_colour(ATTR_W'($urandom_range(0, 255)));
    hold_tog <= ~hold_tog;
    run_random(400);

    set_colour(ATTR_W'($urandom_range(0, 255)));
    run_random(400);

    drain();
    $display("%0d items sent, %0d results checked; %0d scrolls, %0d wraps past the bottom row",
             sent_cnt, checked_cnt, scroll_cnt, bottom_wrap_cnt);
    $display("colours 0x0F, 0x00, 0xFF and random; one long receiver hold-off");
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
